FILE: rtl/fmhs_pkg.sv
// ============================================================================
// fmhs_pkg
// Types, constants and lookup functions shared by the fan mode and
// humidifier sequencer.
// ============================================================================
package fmhs_pkg;

    localparam int PATTERN_STEPS  = 17;
    localparam int TICKS_PER_STEP = 5;

    localparam logic [1:0] MODE_MANUAL  = 2'd0;
    localparam logic [1:0] MODE_NATURAL = 2'd1;
    localparam logic [1:0] MODE_SLEEP   = 2'd2;

    localparam logic [3:0] WIND_OFF      = 4'd15;
    localparam logic [3:0] FAN_BITS_IDLE = 4'hE;
    localparam logic [6:0] PINS_IDLE     = 7'd126;

    localparam int PIN_HUMID  = 4;
    localparam int PIN_SWING  = 5;
    localparam int PIN_IONIZE = 6;

    localparam logic [7:0] SLEEP_LIMIT_RESET = 8'd6;
    localparam logic [7:0] COUNT_WRAP_TO     = 8'd12;

    typedef struct packed {
        logic       power_on;
        logic       second_tick;
        logic       pattern_tick;
        logic [1:0] fan_mode;
        logic [2:0] fan_speed;
        logic       humidify_on;
        logic       water_sensor;
        logic       swing_on;
        logic       ionizer_on;
    } in_word_t;

    typedef struct packed {
        logic [6:0] drive_pins;
        logic       shortage_led;
        logic       led_refresh;
        logic [2:0] speed_next;
        logic       speed_lowered;
        logic       second_tick_taken;
        logic       pattern_tick_taken;
    } out_word_t;

    // Boost, low, mid and high pin levels for one speed code.
    function automatic logic [3:0] fan_bits(input logic [2:0] x);
        logic [3:0] bits;
        bits = FAN_BITS_IDLE;
        if (x >= 3'd3) bits[0] = 1'b1;
        if (x == 3'd0 || x == 3'd3) bits[1] = 1'b0;
        else if (x == 3'd1 || x == 3'd4) bits[2] = 1'b0;
        else if (x == 3'd2 || x == 3'd5) bits[3] = 1'b0;
        return bits;
    endfunction

    function automatic logic [3:0] wind_bits(input logic [3:0] code);
        logic [3:0] bits;
        if (code == WIND_OFF) bits = FAN_BITS_IDLE;
        else bits = fan_bits(code[2:0]);
        return bits;
    endfunction

    function automatic logic [3:0] wind_high(input logic [4:0] step);
        logic [3:0] c;
        unique case (step)
            5'd0:  c = 4'd5;
            5'd1:  c = 4'd3;
            5'd2:  c = 4'd1;
            5'd3:  c = 4'd5;
            5'd4:  c = 4'd3;
            5'd5:  c = 4'd5;
            5'd6:  c = WIND_OFF;
            5'd7:  c = 4'd3;
            5'd8:  c = 4'd5;
            5'd9:  c = 4'd1;
            5'd10: c = 4'd5;
            5'd11: c = 4'd3;
            5'd12: c = 4'd5;
            5'd13: c = WIND_OFF;
            5'd14: c = 4'd3;
            5'd15: c = 4'd5;
            5'd16: c = 4'd1;
            default: c = WIND_OFF;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] wind_mid(input logic [4:0] step);
        logic [3:0] c;
        unique case (step)
            5'd0:  c = 4'd3;
            5'd1:  c = 4'd1;
            5'd2:  c = 4'd5;
            5'd3:  c = WIND_OFF;
            5'd4:  c = 4'd3;
            5'd5:  c = 4'd1;
            5'd6:  c = 4'd5;
            5'd7:  c = WIND_OFF;
            5'd8:  c = 4'd3;
            5'd9:  c = 4'd5;
            5'd10: c = 4'd1;
            5'd11: c = 4'd3;
            5'd12: c = 4'd1;
            5'd13: c = 4'd5;
            5'd14: c = WIND_OFF;
            5'd15: c = 4'd3;
            5'd16: c = 4'd1;
            default: c = WIND_OFF;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] wind_low(input logic [4:0] step);
        logic [3:0] c;
        unique case (step)
            5'd0:  c = 4'd3;
            5'd1:  c = 4'd1;
            5'd2:  c = 4'd3;
            5'd3:  c = 4'd1;
            5'd4:  c = WIND_OFF;
            5'd5:  c = 4'd5;
            5'd6:  c = 4'd1;
            5'd7:  c = 4'd3;
            5'd8:  c = 4'd1;
            5'd9:  c = WIND_OFF;
            5'd10: c = 4'd3;
            5'd11: c = 4'd1;
            5'd12: c = 4'd3;
            5'd13: c = WIND_OFF;
            5'd14: c = 4'd5;
            5'd15: c = 4'd1;
            5'd16: c = 4'd3;
            default: c = WIND_OFF;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] count_second(input logic [7:0] c);
        return (c == 8'hFF) ? COUNT_WRAP_TO : c + 8'd1;
    endfunction

endpackage

FILE: rtl/fmhs_core.sv
// ============================================================================
// fmhs_core
// Control state of the sequencer and the logic of one control pass.
// ============================================================================
module fmhs_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  fmhs_pkg::in_word_t word,
    input  logic [7:0]         sleep_limit,
    output fmhs_pkg::out_word_t result
);

    typedef struct packed {
        logic       startup_done;
        logic [7:0] second_count;
        logic [2:0] tick_divider;
        logic [4:0] pattern_step;
        logic [7:0] sleep_count;
        logic [2:0] applied_speed;
        logic       last_power;
        logic       last_humidify;
        logic       humidify_active;
        logic       water_low;
        logic [2:0] dry_count;
        logic       last_swing;
        logic       last_ionizer;
        logic [6:0] pin_levels;
        logic       shortage_led_on;
    } core_state_t;

    core_state_t st_reg;
    core_state_t st_next;

    logic       sec;
    logic [2:0] speed;
    logic [3:0] code;
    logic       refresh;
    logic       lowered;
    logic       sec_taken;
    logic       pat_taken;

    always_comb
    begin
        st_next   = st_reg;
        sec       = word.second_tick;
        speed     = word.fan_speed;
        code      = fmhs_pkg::WIND_OFF;
        refresh   = 1'b0;
        lowered   = 1'b0;
        sec_taken = 1'b0;
        pat_taken = 1'b0;

        if (word.power_on)
        begin
            st_next.last_power = 1'b1;
            if (!st_reg.startup_done)
            begin
                if (sec)
                begin
                    sec       = 1'b0;
                    sec_taken = 1'b1;
                    st_next.second_count = fmhs_pkg::count_second(st_reg.second_count);
                    if (st_next.second_count == 8'd1)
                    begin
                        st_next.pin_levels[3:0] = fmhs_pkg::fan_bits(3'd4);
                        st_next.applied_speed   = 3'd4;
                    end
                    else if (st_next.second_count == 8'd3)
                    begin
                        st_next.startup_done = 1'b1;
                    end
                end
            end
            else if (word.fan_mode == fmhs_pkg::MODE_NATURAL ||
                     word.fan_mode == fmhs_pkg::MODE_SLEEP)
            begin
                if (word.pattern_tick)
                begin
                    pat_taken = 1'b1;
                    st_next.tick_divider = st_reg.tick_divider + 3'd1;
                    if (st_next.tick_divider == 3'(fmhs_pkg::TICKS_PER_STEP))
                    begin
                        st_next.tick_divider = 3'd0;
                        st_next.pattern_step = st_reg.pattern_step + 5'd1;
                        if (st_next.pattern_step >= 5'(fmhs_pkg::PATTERN_STEPS))
                        begin
                            st_next.pattern_step = 5'd0;
                            st_next.sleep_count  = st_reg.sleep_count + 8'd1;
                            if (st_next.sleep_count > sleep_limit)
                            begin
                                st_next.sleep_count = 8'd0;
                                if (word.fan_mode == fmhs_pkg::MODE_SLEEP && speed > 3'd1)
                                begin
                                    speed   = speed - 3'd2;
                                    lowered = 1'b1;
                                end
                            end
                        end
                    end
                    if (speed > 3'd3) code = fmhs_pkg::wind_high(st_next.pattern_step);
                    else if (speed > 3'd1) code = fmhs_pkg::wind_mid(st_next.pattern_step);
                    else code = fmhs_pkg::wind_low(st_next.pattern_step);
                    if (st_next.pattern_step < 5'(fmhs_pkg::PATTERN_STEPS))
                        st_next.pin_levels[3:0] = fmhs_pkg::wind_bits(code);
                end
            end
            else if (word.fan_mode == fmhs_pkg::MODE_MANUAL &&
                     st_reg.applied_speed != speed)
            begin
                st_next.applied_speed   = speed;
                st_next.pin_levels[3:0] = fmhs_pkg::fan_bits(speed);
            end

            if (st_reg.last_humidify != word.humidify_on)
            begin
                st_next.last_humidify = word.humidify_on;
                if (word.humidify_on)
                begin
                    st_next.humidify_active = 1'b1;
                end
                else
                begin
                    st_next.humidify_active = 1'b0;
                    st_next.second_count    = 8'd0;
                    st_next.shortage_led_on = 1'b0;
                    st_next.water_low       = 1'b0;
                    refresh                 = 1'b1;
                end
            end

            if (st_next.humidify_active && sec)
            begin
                sec_taken = 1'b1;
                st_next.second_count = fmhs_pkg::count_second(st_next.second_count);
                if (!st_next.water_low)
                begin
                    priority if (st_next.second_count == 8'd1)
                        st_next.pin_levels[fmhs_pkg::PIN_HUMID] = 1'b0;
                    else if (st_next.second_count == 8'd4)
                        st_next.pin_levels[fmhs_pkg::PIN_HUMID] = 1'b1;
                    else if (st_next.second_count == 8'd6)
                        st_next.pin_levels[fmhs_pkg::PIN_HUMID] = 1'b0;
                    else if (st_next.second_count == 8'd9)
                        st_next.pin_levels[fmhs_pkg::PIN_HUMID] = 1'b1;
                    else if (st_next.second_count == 8'd11)
                    begin
                        st_next.pin_levels[fmhs_pkg::PIN_HUMID] = 1'b0;
                        st_next.dry_count = 3'd0;
                    end
                    else if (st_next.second_count > 8'd11)
                    begin
                        st_next.dry_count = word.water_sensor ? st_reg.dry_count + 3'd1 : 3'd0;
                        if (st_next.dry_count == 3'd4)
                        begin
                            st_next.dry_count = 3'd0;
                            st_next.pin_levels[fmhs_pkg::PIN_HUMID] = 1'b1;
                            st_next.water_low = 1'b1;
                        end
                    end
                    else
                    begin
                    end
                end
                else
                begin
                    st_next.shortage_led_on = ~st_next.shortage_led_on;
                    refresh                 = 1'b1;
                end
            end

            if (st_reg.last_swing != word.swing_on)
            begin
                st_next.last_swing = word.swing_on;
                st_next.pin_levels[fmhs_pkg::PIN_SWING] = ~word.swing_on;
            end
            if (st_reg.last_ionizer != word.ionizer_on)
            begin
                st_next.last_ionizer = word.ionizer_on;
                st_next.pin_levels[fmhs_pkg::PIN_IONIZE] = ~word.ionizer_on;
            end
        end
        else if (st_reg.last_power)
        begin
            st_next.last_power = 1'b0;
            st_next.pin_levels = fmhs_pkg::PINS_IDLE;
        end

        result.drive_pins         = st_next.pin_levels;
        result.shortage_led       = st_next.shortage_led_on;
        result.led_refresh        = refresh;
        result.speed_next         = speed;
        result.speed_lowered      = lowered;
        result.second_tick_taken  = sec_taken;
        result.pattern_tick_taken = pat_taken;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Everything clears except the pins, which rest inactive. The 37
            // zero bits cover all fields above pin_levels.
            st_reg <= core_state_t'({37'd0, fmhs_pkg::PINS_IDLE, 1'b0});
        end
        else if (step_en)
        begin
            st_reg <= st_next;
        end
    end

endmodule

FILE: rtl/fan_mode_and_humidifier_sequencer.sv
// ============================================================================
// fan_mode_and_humidifier_sequencer
// Fan speed, wind pattern and humidifier control, one control pass per word.
// ============================================================================
// Usage:
// Each input word on the in channel (valid/ready) is one control pass: power
// level, pending second and pattern flags, mode, speed and the humidifier,
// water sensor, swing and ionizer levels. For every accepted input word the
// block returns exactly one output word on the out channel (valid/ready)
// with the pin levels, the LED state, the speed after the pass and the
// flags that report which pending ticks were consumed.
// A word accepted on the in channel is captured in the input register, the
// pass is evaluated into the result register once that register is free,
// and the result is offered from then on.
// Throughput is one word per cycle while the receiver does not stall; the
// limit is the pass through the control state, which is updated once per word.
// When the receiver stalls, the result register holds its word and the
// input register can still take one more word; in_ready falls only when
// both are full, so no word is lost. Reset (rst_n low, asynchronous)
// clears the start-up flag, counters and edge memories, sets all pins
// inactive and sets sleep_limit to six. The user writes sleep_limit via
// cfg_we/cfg_wdata only while the block is idle; the block does not check.
// ============================================================================
module fan_mode_and_humidifier_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fmhs_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output fmhs_pkg::out_word_t out_word,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata
);

    // Configuration register.
    logic [7:0] sleep_limit_reg;

    // Input register stage.
    logic               hold_valid_reg;
    fmhs_pkg::in_word_t hold_word_reg;

    // Result register stage.
    logic                out_valid_reg;
    fmhs_pkg::out_word_t out_word_reg;

    fmhs_pkg::out_word_t pass_result;
    logic                res_free;
    logic                advance;

    // The result register can take a new word when it is empty or its word
    // leaves in this cycle; the held input word then moves on.
    assign res_free = !out_valid_reg || out_ready;
    assign advance  = hold_valid_reg && res_free;
    assign in_ready = !hold_valid_reg || res_free;

    fmhs_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .word        (hold_word_reg),
        .sleep_limit (sleep_limit_reg),
        .result      (pass_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sleep_limit_reg <= fmhs_pkg::SLEEP_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            sleep_limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                hold_valid_reg <= 1'b1;
            else if (advance)
                hold_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            hold_word_reg <= in_word;
        if (advance)
            out_word_reg <= pass_result;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
